FILE: hw/rtl/mrr_pkg.sv
// Shared types, constants and helper functions for the motion record and reverse replay unit.
// Has no dependencies. The top level refers to it by scoped names; mrr_ram does not use it.
package mrr_pkg;

    // Ring store geometry
    localparam int RING_DEPTH = 512;
    localparam int IDX_W      = $clog2(RING_DEPTH);

    // A tick that brings the hold count up to this value commits the entry.
    localparam logic [7:0] HOLD_LIMIT = 8'hff;

    // Action codes
    localparam logic [2:0] ACT_SPEED     = 3'd0;
    localparam logic [2:0] ACT_COMMIT    = 3'd1;
    localparam logic [2:0] ACT_TICK      = 3'd2;
    localparam logic [2:0] ACT_BACKTRACK = 3'd3;
    localparam logic [2:0] ACT_CLEAR     = 3'd4;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [2:0]        action;
        logic signed [7:0] left_speed;
        logic signed [7:0] right_speed;
    } item_t;

    typedef struct packed {
        logic              drive_update;
        logic signed [7:0] drive_left;
        logic signed [7:0] drive_right;
        logic              release_locks;
        logic              recording;
    } result_t;

    typedef struct packed {
        logic signed [7:0] left_speed;
        logic signed [7:0] right_speed;
        logic [7:0]        hold;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic idx_t ring_next(input idx_t i);
        if (i == idx_t'(RING_DEPTH - 1)) begin
            return '0;
        end
        return i + idx_t'(1);
    endfunction

    function automatic idx_t ring_prev(input idx_t i);
        if (i == '0) begin
            return idx_t'(RING_DEPTH - 1);
        end
        return i - idx_t'(1);
    endfunction

    // Negation with the most negative code saturating to the most positive.
    function automatic logic signed [7:0] neg_sat(input logic signed [7:0] v);
        if (v == -8'sd128) begin
            return 8'sd127;
        end
        return -v;
    endfunction

endpackage

FILE: hw/rtl/motion_record_reverse_replay_unit.sv
// Top level of the motion record and reverse replay unit: control logic, index registers
// and output register. Depends on mrr_pkg and on mrr_ram for the entry ring store.
//
// Usage: each transaction on the s_ channel carries one action (speed, commit, tick,
// backtrack or clear) with a speed pair, and produces exactly one transaction on the m_
// channel holding the drive update, the drive speeds, the lock release flag and the
// current mode. Speed pairs are held in registers until committed; a commit writes the
// pair and its hold time into the ring store in one write.
// Most actions are handled as they are accepted; their result appears in the output
// register on the next cycle. A replay tick that pops an entry reads the ring store,
// whose read port is registered, and s_ready is low while that read is outstanding.
// The sustained rate is one action per cycle while the receiver keeps up; a popping
// replay tick blocks the next action until its entry has been read.
// Reset (aresetn low, synchronous) returns the unit to record mode with an empty ring;
// the store contents are not cleared and are never read before being written.
// When the receiver stalls, the pending result is held in the output register and no
// further transaction is accepted until it has been taken.
module motion_record_reverse_replay_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mrr_pkg::item_t  s_item,
    output logic            m_valid,
    input  logic            m_ready,
    output mrr_pkg::result_t m_result
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t state_reg, state_next;

    mrr_pkg::idx_t write_idx_reg,  write_idx_next;
    mrr_pkg::idx_t oldest_idx_reg, oldest_idx_next;
    mrr_pkg::idx_t last_idx_reg,   last_idx_next;
    logic [7:0]    hold_reg,       hold_next;
    logic          record_reg,     record_next;
    logic          pending_reg,    pending_next;
    logic          done_reg,       done_next;
    logic signed [7:0] pair_left_reg,  pair_left_next;
    logic signed [7:0] pair_right_reg, pair_right_next;
    logic              out_valid_reg,  out_valid_next;
    mrr_pkg::result_t  out_result_reg, out_result_next;

    logic                            ram_we;
    mrr_pkg::idx_t                   ram_waddr;
    mrr_pkg::entry_t                 ram_wentry;
    logic                            ram_re;
    logic [mrr_pkg::ENTRY_W-1:0]     ram_rdata;
    mrr_pkg::entry_t                 rd_entry;

    logic          accept;
    logic          emit;
    mrr_pkg::idx_t commit_widx;
    mrr_pkg::idx_t commit_oldest;
    logic [7:0]    hold_inc;
    logic [7:0]    hold_dec;

    assign s_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;
    assign rd_entry = mrr_pkg::entry_t'(ram_rdata);

    // Index values after a commit; the oldest entry is dropped when the ring fills.
    assign commit_widx   = mrr_pkg::ring_next(write_idx_reg);
    assign commit_oldest = (commit_widx == oldest_idx_reg) ?
                           mrr_pkg::ring_next(oldest_idx_reg) : oldest_idx_reg;
    assign hold_inc      = hold_reg + 8'd1;
    assign hold_dec      = (hold_reg != 8'd0) ? hold_reg - 8'd1 : 8'd0;

    mrr_ram #(
        .WIDTH (mrr_pkg::ENTRY_W),
        .DEPTH (mrr_pkg::RING_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (write_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        write_idx_next  = write_idx_reg;
        oldest_idx_next = oldest_idx_reg;
        last_idx_next   = last_idx_reg;
        hold_next       = hold_reg;
        record_next     = record_reg;
        pending_next    = pending_reg;
        done_next       = done_reg;
        pair_left_next  = pair_left_reg;
        pair_right_next = pair_right_reg;
        ram_we          = 1'b0;
        ram_waddr       = write_idx_reg;
        ram_wentry      = '{left_speed: pair_left_reg, right_speed: pair_right_reg,
                            hold: hold_reg};
        ram_re          = 1'b0;
        emit            = 1'b0;
        out_result_next = out_result_reg;
        out_valid_next  = out_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    emit                          = 1'b1;
                    out_result_next               = '0;
                    unique case (s_item.action)
                        mrr_pkg::ACT_SPEED: begin
                            if (record_reg && !(s_item.left_speed == 8'sd0 &&
                                                s_item.right_speed == 8'sd0)) begin
                                pair_left_next  = s_item.left_speed;
                                pair_right_next = s_item.right_speed;
                                pending_next    = 1'b1;
                            end
                        end
                        mrr_pkg::ACT_COMMIT: begin
                            if (record_reg && pending_reg) begin
                                ram_we          = 1'b1;
                                last_idx_next   = write_idx_reg;
                                write_idx_next  = commit_widx;
                                oldest_idx_next = commit_oldest;
                                hold_next       = 8'd0;
                                pending_next    = 1'b0;
                                done_next       = 1'b0;
                            end
                        end
                        mrr_pkg::ACT_TICK: begin
                            if (record_reg) begin
                                if (pending_reg) begin
                                    if (hold_inc == mrr_pkg::HOLD_LIMIT) begin
                                        // Commit at the limit; the pair stays staged.
                                        ram_we          = 1'b1;
                                        ram_wentry.hold = hold_inc;
                                        last_idx_next   = write_idx_reg;
                                        write_idx_next  = commit_widx;
                                        oldest_idx_next = commit_oldest;
                                        hold_next       = 8'd0;
                                        done_next       = 1'b0;
                                    end else begin
                                        hold_next = hold_inc;
                                    end
                                end else begin
                                    hold_next = 8'd0;
                                end
                            end else begin
                                hold_next = hold_dec;
                                if (hold_dec == 8'd0) begin
                                    if (!done_reg) begin
                                        // The result is issued once the entry is read.
                                        emit       = 1'b0;
                                        ram_re     = 1'b1;
                                        state_next = ST_READ;
                                    end else begin
                                        write_idx_next  = '0;
                                        oldest_idx_next = '0;
                                        last_idx_next   = '0;
                                        hold_next       = 8'd0;
                                        record_next     = 1'b1;
                                        pending_next    = 1'b0;
                                        done_next       = 1'b1;
                                        out_result_next.drive_update  = 1'b1;
                                        out_result_next.release_locks = 1'b1;
                                    end
                                end
                            end
                        end
                        mrr_pkg::ACT_BACKTRACK: begin
                            if (record_reg) begin
                                if (pending_reg) begin
                                    ram_we          = 1'b1;
                                    last_idx_next   = write_idx_reg;
                                    write_idx_next  = write_idx_reg;
                                    oldest_idx_next = commit_oldest;
                                    done_next       = 1'b0;
                                end else begin
                                    write_idx_next  = last_idx_reg;
                                end
                                hold_next    = 8'd0;
                                pending_next = 1'b0;
                                record_next  = 1'b0;
                            end
                        end
                        mrr_pkg::ACT_CLEAR: begin
                            write_idx_next  = '0;
                            oldest_idx_next = '0;
                            last_idx_next   = '0;
                            hold_next       = 8'd0;
                            record_next     = 1'b1;
                            pending_next    = 1'b0;
                            done_next       = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    out_result_next.recording = record_next;
                end
            end
            ST_READ: begin
                emit            = 1'b1;
                hold_next       = rd_entry.hold;
                write_idx_next  = mrr_pkg::ring_prev(write_idx_reg);
                if (write_idx_reg == oldest_idx_reg) begin
                    done_next = 1'b1;
                end
                out_result_next = '{drive_update:  1'b1,
                                    drive_left:    mrr_pkg::neg_sat(rd_entry.left_speed),
                                    drive_right:   mrr_pkg::neg_sat(rd_entry.right_speed),
                                    release_locks: 1'b0,
                                    recording:     1'b0};
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            write_idx_reg  <= '0;
            oldest_idx_reg <= '0;
            last_idx_reg   <= '0;
            hold_reg       <= 8'd0;
            record_reg     <= 1'b1;
            pending_reg    <= 1'b0;
            done_reg       <= 1'b1;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            write_idx_reg  <= write_idx_next;
            oldest_idx_reg <= oldest_idx_next;
            last_idx_reg   <= last_idx_next;
            hold_reg       <= hold_next;
            record_reg     <= record_next;
            pending_reg    <= pending_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
        end
        pair_left_reg  <= pair_left_next;
        pair_right_reg <= pair_right_next;
        out_result_reg <= out_result_next;
    end

    // No new transaction may be taken while a store read is outstanding.
    a_no_accept_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !s_ready)
        else $error("transaction accepted during a store read");

    // A store read always ends in a drive update on the following cycle.
    a_read_gives_update: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> m_valid && m_result.drive_update && !m_result.recording)
        else $error("store read did not produce a drive update");

    // Reads only happen while replaying.
    a_read_only_in_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !record_reg)
        else $error("store read while recording");

    // A staged pair is always committed before replay starts.
    a_pending_only_recording: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> record_reg)
        else $error("pending entry left over in replay mode");

    // The end of a replay always returns the unit to record mode.
    a_release_records: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.release_locks |-> m_result.recording && m_result.drive_update)
        else $error("lock release without return to record mode");

endmodule

FILE: hw/rtl/mrr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Has no dependencies; width and depth are set by parameters.
module mrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
